>>> hw/rtl/asw_pkg.sv
// Shared types, constants and the arctangent table of the steering weight block.
`default_nettype none
package asw_pkg;

  // Default and maximum number of CORDIC rotations
  localparam int unsigned ASW_CORDIC_STAGES = 16;
  localparam int unsigned ASW_MAX_STAGES    = 24;

  // Field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned DIR_W  = 16;
  localparam int unsigned WAVE_W = 24;
  localparam int unsigned TURN_W = 24;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned CFG_W  = 24;

  // CORDIC datapath widths: Q2.30 vector with guard bits, angle in 2^-24 turn
  localparam int unsigned XY_W = 34;
  localparam int unsigned Z_W  = 25;

  // 1/(2*pi) in Q0.64, split into 32-bit halves
  localparam logic [31:0] INV2PI_HI = 32'h28BE60DB;
  localparam logic [31:0] INV2PI_LO = 32'h9391054A;

  // Start value of x: inverse CORDIC gain in Q2.30
  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WAVENUMBER = 2'd0,
    REG_DIR_X      = 2'd1,
    REG_DIR_Y      = 2'd2,
    REG_DIR_Z      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        [WAVE_W-1:0] wavenumber;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  dir_z;
  } cfg_t;

  // Control that travels alongside the datapath
  typedef struct packed {
    logic valid;
    logic flip;
    logic last;
  } ctl_t;

  // Rounded arctangent of 2^-i in units of 2^-24 turn
  function automatic logic signed [Z_W-1:0] asw_atan(input int unsigned idx);
    logic signed [Z_W-1:0] val;
    val = '0;
    case (idx)
      0:       val = Z_W'(2097152);
      1:       val = Z_W'(1238021);
      2:       val = Z_W'(654136);
      3:       val = Z_W'(332050);
      4:       val = Z_W'(166669);
      5:       val = Z_W'(83416);
      6:       val = Z_W'(41718);
      7:       val = Z_W'(20860);
      8:       val = Z_W'(10430);
      9:       val = Z_W'(5215);
      10:      val = Z_W'(2608);
      11:      val = Z_W'(1304);
      12:      val = Z_W'(652);
      13:      val = Z_W'(326);
      14:      val = Z_W'(163);
      15:      val = Z_W'(81);
      16:      val = Z_W'(41);
      17:      val = Z_W'(20);
      18:      val = Z_W'(10);
      19:      val = Z_W'(5);
      20:      val = Z_W'(3);
      21:      val = Z_W'(1);
      22:      val = Z_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/asw_phase.sv
// Phase pipeline: dot product, wavenumber scaling, turn reduction and quadrant fold.
`default_nettype none
module asw_phase (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  asw_pkg::cfg_t                        cfg_i,
  input  logic                                 valid_i,
  input  logic signed [asw_pkg::POS_W-1:0]     elem_x_i,
  input  logic signed [asw_pkg::POS_W-1:0]     elem_y_i,
  input  logic signed [asw_pkg::POS_W-1:0]     elem_z_i,
  input  logic                                 last_i,
  output asw_pkg::ctl_t                        ctl_o,
  output logic signed [asw_pkg::Z_W-1:0]       z_o
);
  import asw_pkg::*;

  localparam int unsigned PROD_W = POS_W + DIR_W;
  localparam int unsigned DOT_W  = PROD_W + 2;
  localparam int unsigned ABS_W  = PROD_W;
  localparam int unsigned MAG_W  = 64;

  // Valid and last travel together per stage
  logic [6:0] v_q;
  logic [6:0] last_q;

  // Stage 1: products
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  // Stage 2: magnitude and sign of the dot product
  logic [ABS_W-1:0] abs_q;
  logic [4:0]       neg_q;
  logic signed [DOT_W-1:0] dot_d;
  logic [ABS_W-1:0]        abs_d;
  // Stage 3: scaled magnitude
  logic [MAG_W-1:0] mag_q;
  // Stage 4: partial products with 1/(2*pi)
  logic [31:0] p00_hi_q;
  logic [63:0] p01_q, p10_q, p11_q;
  // Stage 5: middle column sum
  logic [65:0] mid_q;
  logic [63:0] p11b_q;
  // Stage 6: turn magnitude
  logic [TURN_W-1:0] tmag_q;
  logic [63:0]       hi_d;
  // Stage 7: folded angle
  logic [TURN_W-1:0]     turn_d;
  logic                  flip_d;
  logic signed [Z_W-1:0] z_q;
  logic                  flip_q;

  assign dot_d = DOT_W'(px_q) + DOT_W'(py_q) + DOT_W'(pz_q);
  assign abs_d = dot_d[DOT_W-1] ? ABS_W'(-dot_d) : ABS_W'(dot_d);
  assign hi_d  = p11b_q + 64'(mid_q[65:32]);
  // Negative phase wraps to the complement turn
  assign turn_d = neg_q[4] ? (TURN_W'(0) - tmag_q) : tmag_q;
  // A turn outside [-1/4, 1/4) moves by half a turn: flip the top bit
  assign flip_d = turn_d[TURN_W-1] ^ turn_d[TURN_W-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q   <= {last_q[5:0], last_i};
      neg_q    <= {neg_q[3:0], dot_d[DOT_W-1]};
      px_q     <= elem_x_i * cfg_i.dir_x;
      py_q     <= elem_y_i * cfg_i.dir_y;
      pz_q     <= elem_z_i * cfg_i.dir_z;
      abs_q    <= abs_d;
      mag_q    <= MAG_W'(abs_q) * MAG_W'(cfg_i.wavenumber);
      p00_hi_q <= 32'((64'(mag_q[31:0]) * 64'(INV2PI_LO)) >> 32);
      p01_q    <= 64'(mag_q[31:0]) * 64'(INV2PI_HI);
      p10_q    <= 64'(mag_q[63:32]) * 64'(INV2PI_LO);
      p11_q    <= 64'(mag_q[63:32]) * 64'(INV2PI_HI);
      mid_q    <= 66'(p01_q) + 66'(p10_q) + 66'(p00_hi_q);
      p11b_q   <= p11_q;
      tmag_q   <= hi_d[40:17];
      z_q      <= Z_W'($signed({turn_d[TURN_W-1] ^ flip_d, turn_d[TURN_W-2:0]}));
      flip_q   <= flip_d;
    end
  end

  assign ctl_o.valid = v_q[6];
  assign ctl_o.flip  = flip_q;
  assign ctl_o.last  = last_q[6];
  assign z_o         = z_q;

endmodule
`default_nettype wire

>>> hw/rtl/asw_cordic.sv
// Unrolled rotation CORDIC, one register stage per rotation.
`default_nettype none
module asw_cordic #(
  parameter int unsigned CORDIC_STAGES = asw_pkg::ASW_CORDIC_STAGES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  asw_pkg::ctl_t                        ctl_i,
  input  logic signed [asw_pkg::Z_W-1:0]       z_i,
  output asw_pkg::ctl_t                        ctl_o,
  output logic signed [asw_pkg::XY_W-1:0]      x_o,
  output logic signed [asw_pkg::XY_W-1:0]      y_o
);
  import asw_pkg::*;

  logic signed [XY_W-1:0] x_q [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_q [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_q [CORDIC_STAGES];
  ctl_t                   c_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN = asw_atan(i);
    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]  z_in;
    ctl_t                   c_in;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = z_i;
      assign c_in = ctl_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign c_in = c_q[i-1];
    end

    // Arithmetic shift rounds toward minus infinity
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q[i] <= '0;
      end else if (en_i) begin
        c_q[i] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[Z_W-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - ATAN;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + ATAN;
        end
      end
    end
  end

  assign ctl_o = c_q[CORDIC_STAGES-1];
  assign x_o   = x_q[CORDIC_STAGES-1];
  assign y_o   = y_q[CORDIC_STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/array_steering_weight.sv
// Top level of the phased-array steering weight generator.
// Pipeline: seven phase stages, one per CORDIC rotation, one output register.
// Throughput: one element per clock unless a full output register stalls it;
// the whole pipeline advances on a single enable.
// Reset clears all valid bits and loads wavenumber 0, direction (0, 0, 32767).
// No clearing pass; the block accepts transactions in the first cycle after reset.
`default_nettype none
module array_steering_weight #(
  parameter int unsigned CORDIC_STAGES = asw_pkg::ASW_CORDIC_STAGES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [asw_pkg::CFG_W-1:0]          cfg_data_i,
  // Element positions in
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [asw_pkg::POS_W-1:0]   elem_x_i,
  input  logic signed [asw_pkg::POS_W-1:0]   elem_y_i,
  input  logic signed [asw_pkg::POS_W-1:0]   elem_z_i,
  input  logic                               last_in_i,
  // Complex weights out
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [asw_pkg::WGT_W-1:0]   weight_real_o,
  output logic signed [asw_pkg::WGT_W-1:0]   weight_imag_o,
  output logic                               last_out_o
);
  import asw_pkg::*;

  localparam int unsigned RND_W = XY_W + 2;

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wavenumber <= '0;
      cfg_q.dir_x      <= '0;
      cfg_q.dir_y      <= '0;
      cfg_q.dir_z      <= DIR_W'(32767);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WAVENUMBER: cfg_q.wavenumber <= cfg_data_i[WAVE_W-1:0];
        REG_DIR_X:      cfg_q.dir_x      <= cfg_data_i[DIR_W-1:0];
        REG_DIR_Y:      cfg_q.dir_y      <= cfg_data_i[DIR_W-1:0];
        REG_DIR_Z:      cfg_q.dir_z      <= cfg_data_i[DIR_W-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Pipeline enable. Advance whenever the output register is free or being
  // drained, or when nothing is about to land in it; otherwise hold every stage.
  logic                   en;
  ctl_t                   ph_ctl, cr_ctl;
  logic signed [Z_W-1:0]  ph_z;
  logic signed [XY_W-1:0] cr_x, cr_y;
  logic                   take;

  assign en         = !out_valid_o || out_ready_i || !cr_ctl.valid;
  assign in_ready_o = en;
  assign take       = en && cr_ctl.valid;

  asw_phase u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .valid_i  (in_valid_i),
    .elem_x_i (elem_x_i),
    .elem_y_i (elem_y_i),
    .elem_z_i (elem_z_i),
    .last_i   (last_in_i),
    .ctl_o    (ph_ctl),
    .z_o      (ph_z)
  );

  asw_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ph_ctl),
    .z_i    (ph_z),
    .ctl_o  (cr_ctl),
    .x_o    (cr_x),
    .y_o    (cr_y)
  );

  // Q2.30 to Q1.15: round half up, clamp to +-32767
  function automatic logic signed [WGT_W-1:0] to_q15(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] r;
    logic signed [WGT_W-1:0] res;
    r = (v + RND_W'(16384)) >>> 15;
    if (r > RND_W'(32767)) begin
      res = WGT_W'(32767);
    end else if (r < -RND_W'(32767)) begin
      res = -WGT_W'(32767);
    end else begin
      res = r[WGT_W-1:0];
    end
    return res;
  endfunction

  // Undo the half-turn fold by negating the vector; imaginary part is -sin
  logic signed [RND_W-1:0] re_v, im_v;
  assign re_v = cr_ctl.flip ? -RND_W'(cr_x) : RND_W'(cr_x);
  assign im_v = cr_ctl.flip ? RND_W'(cr_y) : -RND_W'(cr_y);

  // Output register: holds a result while the downstream ready is low
  logic out_valid_q, out_valid_d;
  logic signed [WGT_W-1:0] re_q, im_q;
  logic last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      re_q   <= to_q15(re_v);
      im_q   <= to_q15(im_v);
      last_q <= cr_ctl.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign weight_real_o = re_q;
  assign weight_imag_o = im_q;
  assign last_out_o    = last_q;

endmodule
`default_nettype wire
